/* src/gzmhc_pkg.sv */
// Package with payload types and code constants for the gzip member header checker.
`default_nettype none

package gzmhc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } gzmhc_in_t;

  typedef struct packed {
    logic [1:0]  byte_class;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic [31:0] trailer_crc;
    logic [31:0] trailer_isize;
    logic        member_end;
  } gzmhc_out_t;

  // Configuration register indexes.
  localparam logic CFG_MEMBER_LENGTH = 1'b0;
  localparam logic CFG_SIZE_LIMIT    = 1'b1;

  // Byte classes.
  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_PAYLOAD = 2'd1;
  localparam logic [1:0] CLS_TRAILER = 2'd2;
  localparam logic [1:0] CLS_IGNORED = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_RUNNING        = 4'd0;
  localparam logic [3:0] ST_MEMBER_OK      = 4'd1;
  localparam logic [3:0] ST_HDR_INVALID    = 4'd2;
  localparam logic [3:0] ST_RSVD_FLAGS     = 4'd3;
  localparam logic [3:0] ST_XLEN_MISSING   = 4'd4;
  localparam logic [3:0] ST_EXTRA_OVERFLOW = 4'd5;
  localparam logic [3:0] ST_NAME_UNTERM    = 4'd6;
  localparam logic [3:0] ST_COMMENT_UNTERM = 4'd7;
  localparam logic [3:0] ST_HCRC_MISSING   = 4'd8;
  localparam logic [3:0] ST_DEFLATE_MISSING = 4'd9;
  localparam logic [3:0] ST_CAPACITY       = 4'd10;

  // Header constants.
  localparam logic [7:0]  GZ_ID1        = 8'h1f;
  localparam logic [7:0]  GZ_ID2        = 8'h8b;
  localparam logic [7:0]  GZ_CM_DEFLATE = 8'h08;
  localparam logic [7:0]  FLG_RESERVED  = 8'he0;
  localparam int unsigned FLG_FHCRC     = 1;
  localparam int unsigned FLG_FEXTRA    = 2;
  localparam int unsigned FLG_FNAME     = 3;
  localparam int unsigned FLG_FCOMMENT  = 4;
  localparam logic [31:0] MIN_MEMBER_LEN = 32'd18;
  localparam logic [31:0] TRAILER_LEN    = 32'd8;
  localparam logic [31:0] FIXED_LAST_POS = 32'd9;

endpackage

`default_nettype wire

/* src/gzip_member_header_checker_unit.sv */
// Top level of the gzip member header checker: byte classifier, header walker and trailer capture.
//
// Usage: one gzip member byte enters per word on the input channel (in_valid_i/in_ready_o),
// with first set on byte 0 of each member. Every input word yields exactly one output word
// on out_valid_o/out_ready_i holding the byte class, the byte itself, the running status,
// the trailer CRC and ISIZE captures, and a flag on the member's last byte.
// member_length and size_limit are set through the write port (cfg_we_i, cfg_idx_i, cfg_data_i)
// only while no word is in flight: a rule for the user that the block does not enforce.
// Pipeline: an accepted word lands in the input register and its result is written to the
// result register once the output is free (one input register, one result register).
// Throughput: one word per cycle while the receiver does not stall; the only loop is the
// parser state, updated as a word moves from the input register to the result register.
// Reset clears both configuration registers, the parser state and both valid flags; the
// parser then expects byte 0 of a member even without first. When the receiver stalls, the
// result register holds its word, the input register fills, and in_ready_o drops until the
// output drains.
`default_nettype none

module gzip_member_header_checker_unit
  import gzmhc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire gzmhc_in_t   in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output gzmhc_out_t       out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_METHOD, PH_FLAGS, PH_FIXED, PH_XLEN_LO, PH_XLEN_HI,
    PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC0, PH_HCRC1, PH_PSTART, PH_PAYLOAD,
    PH_TRAILER, PH_IGNORE
  } phase_e;

  logic [31:0] member_len_q, size_limit_q;

  logic        in_valid_q, in_valid_d;
  gzmhc_in_t   in_q;
  logic        out_valid_q, out_valid_d;
  gzmhc_out_t  out_q, out_d;
  logic        advance;

  logic [31:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [4:0]  flags_q, flags_d;
  logic [15:0] xrem_q, xrem_d;
  logic [7:0]  xlow_q, xlow_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] size_q, size_d;
  logic [3:0]  latch_q, latch_d;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance || (out_valid_q && !out_ready_i);
  end

  // Parser step for the word in the input register.
  always_comb begin : step
    logic [7:0]  b;
    logic [31:0] p;
    logic [31:0] trailer;
    logic [32:0] p_ext, tr_ext;
    logic [1:0]  cls;
    logic [3:0]  err;
    logic        finished;

    b        = in_q.data_byte;
    p        = in_q.first ? 32'd0 : pos_q;
    phase_d  = in_q.first ? PH_MAGIC0 : phase_q;
    flags_d  = in_q.first ? 5'd0 : flags_q;
    xrem_d   = in_q.first ? 16'd0 : xrem_q;
    xlow_d   = in_q.first ? 8'd0 : xlow_q;
    crc_d    = in_q.first ? 32'd0 : crc_q;
    size_d   = in_q.first ? 32'd0 : size_q;
    latch_d  = in_q.first ? ST_RUNNING : latch_q;
    trailer  = (member_len_q >= MIN_MEMBER_LEN) ? member_len_q - TRAILER_LEN : 32'd0;
    p_ext    = {1'b0, p};
    tr_ext   = {1'b0, trailer};
    cls      = CLS_IGNORED;
    err      = ST_RUNNING;
    finished = 1'b0;

    case (phase_d)
      PH_MAGIC0: begin
        if (member_len_q < MIN_MEMBER_LEN || b != GZ_ID1) err = ST_HDR_INVALID;
        else begin cls = CLS_HEADER; phase_d = PH_MAGIC1; end
      end
      PH_MAGIC1: begin
        if (b != GZ_ID2) err = ST_HDR_INVALID;
        else begin cls = CLS_HEADER; phase_d = PH_METHOD; end
      end
      PH_METHOD: begin
        if (b != GZ_CM_DEFLATE) err = ST_HDR_INVALID;
        else begin cls = CLS_HEADER; phase_d = PH_FLAGS; end
      end
      PH_FLAGS: begin
        if ((b & FLG_RESERVED) != 8'd0) err = ST_RSVD_FLAGS;
        else begin flags_d = b[4:0]; cls = CLS_HEADER; phase_d = PH_FIXED; end
      end
      PH_FIXED: begin
        cls = CLS_HEADER;
        if (p >= FIXED_LAST_POS) phase_d = PH_XLEN_LO;
      end
      default: begin
        // Fall through absent or finished optional fields, checking each bound.
        if (phase_d == PH_XLEN_LO && !flags_d[FLG_FEXTRA]) phase_d = PH_NAME;
        if (phase_d == PH_XLEN_LO && p_ext + 33'd2 > tr_ext) err = ST_XLEN_MISSING;
        if (err == ST_RUNNING && phase_d == PH_EXTRA && xrem_d == 16'd0) phase_d = PH_NAME;
        if (err == ST_RUNNING && phase_d == PH_NAME && !flags_d[FLG_FNAME])
          phase_d = PH_COMMENT;
        if (err == ST_RUNNING && phase_d == PH_NAME && p >= trailer) err = ST_NAME_UNTERM;
        if (err == ST_RUNNING && phase_d == PH_COMMENT && !flags_d[FLG_FCOMMENT])
          phase_d = PH_HCRC0;
        if (err == ST_RUNNING && phase_d == PH_COMMENT && p >= trailer)
          err = ST_COMMENT_UNTERM;
        if (err == ST_RUNNING && phase_d == PH_HCRC0 && !flags_d[FLG_FHCRC])
          phase_d = PH_PSTART;
        if (err == ST_RUNNING && phase_d == PH_HCRC0 && p_ext + 33'd2 > tr_ext)
          err = ST_HCRC_MISSING;
        if (err == ST_RUNNING && phase_d == PH_PSTART) begin
          if (p >= trailer) err = ST_DEFLATE_MISSING;
          else phase_d = PH_PAYLOAD;
        end
        if (err == ST_RUNNING && phase_d == PH_PAYLOAD && p >= trailer) phase_d = PH_TRAILER;

        if (err == ST_RUNNING) begin
          case (phase_d)
            PH_XLEN_LO: begin
              xlow_d = b; cls = CLS_HEADER; phase_d = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
              if (p_ext + 33'd1 + {17'd0, b, xlow_d} > tr_ext) err = ST_EXTRA_OVERFLOW;
              else begin xrem_d = {b, xlow_d}; cls = CLS_HEADER; phase_d = PH_EXTRA; end
            end
            PH_EXTRA: begin
              xrem_d = xrem_d - 16'd1; cls = CLS_HEADER;
            end
            PH_NAME: begin
              cls = CLS_HEADER;
              if (b == 8'd0) phase_d = PH_COMMENT;
            end
            PH_COMMENT: begin
              cls = CLS_HEADER;
              if (b == 8'd0) phase_d = PH_HCRC0;
            end
            PH_HCRC0: begin
              cls = CLS_HEADER; phase_d = PH_HCRC1;
            end
            PH_HCRC1: begin
              cls = CLS_HEADER; phase_d = PH_PSTART;
            end
            PH_PAYLOAD: begin
              cls = CLS_PAYLOAD;
            end
            PH_TRAILER: begin
              cls = CLS_TRAILER;
              if (tr_ext + 33'd4 > p_ext) crc_d = {b, crc_d[31:8]};
              else size_d = {b, size_d[31:8]};
              if (p_ext + 33'd1 >= {1'b0, member_len_q}) begin
                finished = 1'b1;
                latch_d  = (size_d > size_limit_q) ? ST_CAPACITY : ST_MEMBER_OK;
                phase_d  = PH_IGNORE;
              end
            end
            default: begin
              cls = CLS_IGNORED;
            end
          endcase
        end
      end
    endcase

    if (err != ST_RUNNING) begin
      latch_d = err;
      phase_d = PH_IGNORE;
      cls     = CLS_IGNORED;
    end

    pos_d = (p != 32'hffff_ffff) ? p + 32'd1 : p;

    out_d.byte_class    = cls;
    out_d.payload_byte  = b;
    out_d.status        = latch_d;
    out_d.trailer_crc   = crc_d;
    out_d.trailer_isize = size_d;
    out_d.member_end    = finished ||
                          (latch_d != ST_RUNNING && latch_d != ST_MEMBER_OK &&
                           member_len_q != 32'd0 && p == member_len_q - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_len_q <= 32'd0;
      size_limit_q <= 32'd0;
      in_valid_q   <= 1'b0;
      in_q         <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      pos_q        <= 32'd0;
      phase_q      <= PH_MAGIC0;
      flags_q      <= 5'd0;
      xrem_q       <= 16'd0;
      xlow_q       <= 8'd0;
      crc_q        <= 32'd0;
      size_q       <= 32'd0;
      latch_q      <= ST_RUNNING;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MEMBER_LENGTH) member_len_q <= cfg_data_i;
        if (cfg_idx_i == CFG_SIZE_LIMIT) size_limit_q <= cfg_data_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (in_valid_i && in_ready_o) in_q <= in_data_i;
      if (advance) begin
        out_q   <= out_d;
        pos_q   <= pos_d;
        phase_q <= phase_d;
        flags_q <= flags_d;
        xrem_q  <= xrem_d;
        xlow_q  <= xlow_d;
        crc_q   <= crc_d;
        size_q  <= size_d;
        latch_q <= latch_d;
      end
    end
  end

`ifndef SYNTHESIS
  // A latched status always parks the parser.
  a_latch_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q != ST_RUNNING |-> phase_q == PH_IGNORE)
    else $error("status latched while parser still walking");

  // The last byte of a member always carries a final status.
  a_end_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.member_end |-> out_q.status != ST_RUNNING)
    else $error("member end without final status");

  // Once a status is known, only the closing trailer byte is still classified.
  a_class_after_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_RUNNING && out_q.byte_class != CLS_IGNORED
      |-> out_q.byte_class == CLS_TRAILER && out_q.member_end)
    else $error("byte classified after status was known");

  // A word waiting in the input register stays put until it moves on.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost a waiting word");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Testbench for the gzip member header checker: directed table, random members, model checks.
`timescale 1ns / 1ps

module testbench
  import gzmhc_pkg::*;
();

  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Parser walk through one member, tracked by the predictor.
  typedef enum logic [3:0] {
    P_ID1, P_ID2, P_METHOD, P_FLAGS, P_FIXED, P_XLEN_LO, P_XLEN_HI, P_EXTRA,
    P_NAME, P_COMMENT, P_HCRC_LO, P_HCRC_HI, P_DATA_START, P_DATA, P_TRAILER, P_DONE
  } walk_phase_e;

  typedef struct packed {
    logic        cfg;      // row writes both registers instead of sending a word
    logic [31:0] len;
    logic [31:0] limit;
    logic [7:0]  data;
    logic        first;
    logic        typed;    // want holds the result read straight off the spec
    gzmhc_out_t  want;
  } row_t;

  localparam gzmhc_out_t NO_WANT = '0;
  localparam int DIRECTED_ROWS = 28;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 32'd0, 32'd0, 8'h1f, 1'b0, 1'b1,
      '{CLS_IGNORED, 8'h1f, ST_HDR_INVALID, 32'd0, 32'd0, 1'b0}},
    '{1'b1, 32'd19, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h1f, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h8b, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h08, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'hff, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h5a, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h11, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h22, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h33, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h44, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h01, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b1,
      '{CLS_TRAILER, 8'h00, ST_CAPACITY, 32'h4433_2211, 32'd1, 1'b1}},
    '{1'b0, 32'd0, 32'd0, 8'hff, 1'b0, 1'b1,
      '{CLS_IGNORED, 8'hff, ST_CAPACITY, 32'h4433_2211, 32'd1, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 8'h1f, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h8b, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h08, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'he0, 1'b0, 1'b1,
      '{CLS_IGNORED, 8'he0, ST_RSVD_FLAGS, 32'd0, 32'd0, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 8'h1f, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 32'd0, 32'd0, 8'h00, 1'b0, 1'b1,
      '{CLS_IGNORED, 8'h00, ST_HDR_INVALID, 32'd0, 32'd0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  gzmhc_in_t   in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gzmhc_out_t  out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_MEMBER_LENGTH;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the block's registers and member state.
  logic [31:0] member_len_cfg = '0;
  logic [31:0] size_limit_cfg = '0;
  logic [31:0] byte_pos;
  walk_phase_e walk_phase;
  logic [4:0]  hdr_flags;
  logic [15:0] extra_left;
  logic [7:0]  xlen_lo;
  logic [31:0] crc_cap;
  logic [31:0] size_cap;
  logic [3:0]  status_latch;

  gzmhc_out_t  pending_results[$];
  logic [7:0]  member_q[$];
  bit          steady = 1'b0;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned members_closed = 0;
  int unsigned settings_count = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] status_seen = '0;

  gzip_member_header_checker_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void clear_member();
    byte_pos = '0;
    walk_phase = P_ID1;
    hdr_flags = '0;
    extra_left = '0;
    xlen_lo = '0;
    crc_cap = '0;
    size_cap = '0;
    status_latch = ST_RUNNING;
  endfunction

  function automatic gzmhc_out_t predict_byte(input gzmhc_in_t w);
    gzmhc_out_t r;
    walk_phase_e ph;
    logic [1:0] cls;
    logic [3:0] err;
    logic done;
    longint unsigned p, len, trl, xsize;
    if (w.first) clear_member();
    p = 64'(byte_pos);
    len = 64'(member_len_cfg);
    trl = (len >= 64'(MIN_MEMBER_LEN)) ? len - 64'(TRAILER_LEN) : 64'd0;
    ph = walk_phase;
    cls = CLS_IGNORED;
    err = ST_RUNNING;
    done = 1'b0;
    case (ph)
      P_ID1: begin
        if (len < 64'(MIN_MEMBER_LEN) || w.data_byte != GZ_ID1) err = ST_HDR_INVALID;
        else begin
          cls = CLS_HEADER;
          ph = P_ID2;
        end
      end
      P_ID2: begin
        if (w.data_byte != GZ_ID2) err = ST_HDR_INVALID;
        else begin
          cls = CLS_HEADER;
          ph = P_METHOD;
        end
      end
      P_METHOD: begin
        if (w.data_byte != GZ_CM_DEFLATE) err = ST_HDR_INVALID;
        else begin
          cls = CLS_HEADER;
          ph = P_FLAGS;
        end
      end
      P_FLAGS: begin
        if ((w.data_byte & FLG_RESERVED) != 0) err = ST_RSVD_FLAGS;
        else begin
          hdr_flags = w.data_byte[4:0];
          cls = CLS_HEADER;
          ph = P_FIXED;
        end
      end
      P_FIXED: begin
        cls = CLS_HEADER;
        if (p >= 64'(FIXED_LAST_POS)) ph = P_XLEN_LO;
      end
      default: begin
        // Fall through absent or finished optional fields, each bounded by the trailer.
        if (ph == P_XLEN_LO && !hdr_flags[FLG_FEXTRA]) ph = P_NAME;
        if (ph == P_XLEN_LO && p + 2 > trl) err = ST_XLEN_MISSING;
        if (err == ST_RUNNING && ph == P_EXTRA && extra_left == 0) ph = P_NAME;
        if (err == ST_RUNNING && ph == P_NAME && !hdr_flags[FLG_FNAME]) ph = P_COMMENT;
        if (err == ST_RUNNING && ph == P_NAME && p >= trl) err = ST_NAME_UNTERM;
        if (err == ST_RUNNING && ph == P_COMMENT && !hdr_flags[FLG_FCOMMENT]) ph = P_HCRC_LO;
        if (err == ST_RUNNING && ph == P_COMMENT && p >= trl) err = ST_COMMENT_UNTERM;
        if (err == ST_RUNNING && ph == P_HCRC_LO && !hdr_flags[FLG_FHCRC]) ph = P_DATA_START;
        if (err == ST_RUNNING && ph == P_HCRC_LO && p + 2 > trl) err = ST_HCRC_MISSING;
        if (err == ST_RUNNING && ph == P_DATA_START) begin
          if (p >= trl) err = ST_DEFLATE_MISSING;
          else ph = P_DATA;
        end
        if (err == ST_RUNNING && ph == P_DATA && p >= trl) ph = P_TRAILER;
        if (err == ST_RUNNING) begin
          case (ph)
            P_XLEN_LO: begin
              xlen_lo = w.data_byte;
              cls = CLS_HEADER;
              ph = P_XLEN_HI;
            end
            P_XLEN_HI: begin
              xsize = 64'({w.data_byte, xlen_lo});
              if (p + 1 + xsize > trl) err = ST_EXTRA_OVERFLOW;
              else begin
                extra_left = xsize[15:0];
                cls = CLS_HEADER;
                ph = P_EXTRA;
              end
            end
            P_EXTRA: begin
              extra_left = extra_left - 16'd1;
              cls = CLS_HEADER;
            end
            P_NAME: begin
              cls = CLS_HEADER;
              if (w.data_byte == 8'h00) ph = P_COMMENT;
            end
            P_COMMENT: begin
              cls = CLS_HEADER;
              if (w.data_byte == 8'h00) ph = P_HCRC_LO;
            end
            P_HCRC_LO: begin
              cls = CLS_HEADER;
              ph = P_HCRC_HI;
            end
            P_HCRC_HI: begin
              cls = CLS_HEADER;
              ph = P_DATA_START;
            end
            P_DATA: cls = CLS_PAYLOAD;
            P_TRAILER: begin
              cls = CLS_TRAILER;
              if (p < trl + 4) crc_cap = {w.data_byte, crc_cap[31:8]};
              else size_cap = {w.data_byte, size_cap[31:8]};
              if (p + 1 >= len) begin
                done = 1'b1;
                status_latch = (size_cap > size_limit_cfg) ? ST_CAPACITY : ST_MEMBER_OK;
                ph = P_DONE;
              end
            end
            default: cls = CLS_IGNORED;
          endcase
        end
      end
    endcase
    if (err != ST_RUNNING) begin
      status_latch = err;
      ph = P_DONE;
      cls = CLS_IGNORED;
    end
    walk_phase = ph;
    r.byte_class = cls;
    r.payload_byte = w.data_byte;
    r.status = status_latch;
    r.trailer_crc = crc_cap;
    r.trailer_isize = size_cap;
    r.member_end = done ||
                   (status_latch >= ST_HDR_INVALID && len != 0 && p == len - 1);
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long; none at all in a steady stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Builds a member with random optional fields, cut or padded to total bytes.
  function automatic void build_member(input int unsigned total, input logic [31:0] isize);
    logic [7:0]  flg;
    logic [31:0] crc;
    int unsigned n;
    member_q.delete();
    flg = 8'($urandom_range(0, 31));
    member_q.push_back(GZ_ID1);
    member_q.push_back(GZ_ID2);
    member_q.push_back(GZ_CM_DEFLATE);
    member_q.push_back(flg);
    repeat (6) member_q.push_back(8'($urandom));
    if (flg[FLG_FEXTRA]) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
      member_q.push_back(n[7:0]);
      member_q.push_back(n[15:8]);
      repeat (n) member_q.push_back(8'($urandom));
    end
    if (flg[FLG_FNAME]) begin
      repeat ($urandom_range(0, 5)) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'h00);
    end
    if (flg[FLG_FCOMMENT]) begin
      repeat ($urandom_range(0, 5)) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'h00);
    end
    if (flg[FLG_FHCRC]) repeat (2) member_q.push_back(8'($urandom));
    while (member_q.size() + 8 < total) member_q.push_back(8'($urandom));
    crc = $urandom;
    for (int i = 0; i < 4; i++) member_q.push_back(crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) member_q.push_back(isize[8*i +: 8]);
    while (member_q.size() > total) void'(member_q.pop_back());
  endfunction

  task automatic check_word(input gzmhc_out_t want, input gzmhc_out_t got);
    if (got.byte_class !== want.byte_class) begin
      $error("byte_class: expected %0d, got %0d", want.byte_class, got.byte_class);
      fail_count++;
    end
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %h, got %h", want.payload_byte, got.payload_byte);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.trailer_crc !== want.trailer_crc) begin
      $error("trailer_crc: expected %h, got %h", want.trailer_crc, got.trailer_crc);
      fail_count++;
    end
    if (got.trailer_isize !== want.trailer_isize) begin
      $error("trailer_isize: expected %h, got %h", want.trailer_isize, got.trailer_isize);
      fail_count++;
    end
    if (got.member_end !== want.member_end) begin
      $error("member_end: expected %0d, got %0d", want.member_end, got.member_end);
      fail_count++;
    end
  endtask

  task automatic send_word(input logic [7:0] data, input logic first, input logic typed,
                           input gzmhc_out_t want);
    gzmhc_in_t   w;
    gzmhc_out_t  model_word;
    int unsigned gap;
    w.data_byte = data;
    w.first = first;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model_word = predict_byte(w);
    pending_results.push_back(typed ? want : model_word);
    words_sent++;
    status_seen[model_word.status] = 1'b1;
    if (model_word.member_end) members_closed++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic [31:0] len, input logic [31:0] limit);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MEMBER_LENGTH;
    cfg_data <= len;
    @(negedge clk);
    cfg_idx <= CFG_SIZE_LIMIT;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    member_len_cfg = len;
    size_limit_cfg = limit;
    settings_count++;
  endtask

  // Receiver: ready most cycles, with stalls drawn like the sender's gaps.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        out_ready <= (hold == 0);
        if (hold != 0) hold--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          fail_count++;
        end else begin
          check_word(pending_results.pop_front(), out_word);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start, send_len, members, r, cut;
    logic [31:0] len_cfg, limit, isize;
    logic        carry, noisy, head_first;
    clear_member();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg) begin
        wait_drained();
        write_config(DIRECTED[i].len, DIRECTED[i].limit);
      end else begin
        send_word(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    random_start = words_sent;
    carry = 1'b0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      // Registers change only with nothing in flight; the sender waits here.
      wait_drained();
      r = $urandom_range(0, 19);
      case (r)
        0: len_cfg = '0;
        1: len_cfg = 32'd17;
        2: len_cfg = '1;
        3: len_cfg = $urandom;
        default: len_cfg = (r < 9) ? $urandom_range(18, 30) : $urandom_range(31, 64);
      endcase
      r = $urandom_range(0, 5);
      limit = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      write_config(len_cfg, limit);
      steady = ($urandom_range(0, 4) == 0);
      members = $urandom_range(1, 3);
      for (int m = 0; m <= members; m++) begin
        // The extra pass leaves a member unfinished now and then, so the next
        // register setting meets it partway through.
        if (m == members && $urandom_range(0, 9) != 0) break;
        send_len = (len_cfg >= 18 && len_cfg <= 80) ? len_cfg : $urandom_range(19, 60);
        isize = ($urandom_range(0, 4) < 2) ? limit + 32'($urandom_range(0, 2)) - 32'd1
                                           : $urandom;
        build_member(send_len, isize);
        noisy = 1'b0;
        head_first = !carry;
        r = $urandom_range(0, 99);
        if (m == members) begin
          cut = $urandom_range(1, member_q.size());
          while (member_q.size() > cut) void'(member_q.pop_back());
        end else if (r < 8) begin
          cut = $urandom_range(0, member_q.size() - 1);
          member_q[cut] = member_q[cut] ^ 8'($urandom_range(1, 255));
        end else if (r < 13) begin
          cut = $urandom_range(1, member_q.size());
          while (member_q.size() > cut) void'(member_q.pop_back());
        end else if (r < 18) begin
          repeat ($urandom_range(1, 6)) member_q.push_back(8'($urandom));
        end else if (r < 21) begin
          noisy = 1'b1;
          foreach (member_q[k]) member_q[k] = 8'($urandom);
        end else if (r < 25) begin
          head_first = 1'b0;
        end
        carry = (m == members);
        foreach (member_q[k]) begin
          if (noisy) send_word(member_q[k], ($urandom_range(0, 7) == 0), 1'b0, NO_WANT);
          else send_word(member_q[k], (k == 0) && head_first, 1'b0, NO_WANT);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d words under %0d register settings, %0d members closed.",
             words_sent, settings_count, members_closed);
    $display("Status codes seen (bit per code): %b", status_seen[10:0]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gzmhc_pkg.sv
src/gzip_member_header_checker_unit.sv
verif/testbench.sv
